FILE: rtl/drc_pkg.sv
// Package for the dimmer ramp controller: command codes, register indexes,
// reset values, shared structs and the small frame and clamp helpers.
// No dependencies.
`default_nettype none

package drc_pkg;

    localparam int FrameW = 8;
    localparam int CmdW   = 3;
    localparam int DeltaW = 9;
    localparam int CfgIdxW = 3;

    // Command codes.
    localparam logic [CmdW-1:0] CMD_POWER         = 3'd0;
    localparam logic [CmdW-1:0] CMD_COLOUR_DELTA  = 3'd1;
    localparam logic [CmdW-1:0] CMD_COLOUR_PRESET = 3'd2;
    localparam logic [CmdW-1:0] CMD_BRIGHT_DELTA  = 3'd3;
    localparam logic [CmdW-1:0] CMD_TICK          = 3'd4;

    // Register indexes.
    localparam logic [CfgIdxW-1:0] REG_MAX_BRIGHTNESS      = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MIN_BRIGHTNESS      = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_COLOUR_TEMP     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MIN_COLOUR_TEMP     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DEFAULT_BRIGHTNESS  = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_DEFAULT_COLOUR_TEMP = 3'd5;

    // Register reset values.
    localparam logic [FrameW-1:0] RST_MAX_BRIGHTNESS      = 8'd255;
    localparam logic [FrameW-1:0] RST_MIN_BRIGHTNESS      = 8'd0;
    localparam logic [FrameW-1:0] RST_MAX_COLOUR_TEMP     = 8'd63;
    localparam logic [FrameW-1:0] RST_MIN_COLOUR_TEMP     = 8'd0;
    localparam logic [FrameW-1:0] RST_DEFAULT_BRIGHTNESS  = 8'd128;
    localparam logic [FrameW-1:0] RST_DEFAULT_COLOUR_TEMP = 8'd35;

    // Colour temperature presets, visited in order and wrapping to the first.
    localparam logic [FrameW-1:0] PRESET_0 = 8'd10;
    localparam logic [FrameW-1:0] PRESET_1 = 8'd35;
    localparam logic [FrameW-1:0] PRESET_2 = 8'd60;

    typedef struct packed {
        logic [FrameW-1:0] max_brightness;
        logic [FrameW-1:0] min_brightness;
        logic [FrameW-1:0] max_colour_temp;
        logic [FrameW-1:0] min_colour_temp;
        logic [FrameW-1:0] default_brightness;
        logic [FrameW-1:0] default_colour_temp;
    } drc_cfg_t;

    typedef struct packed {
        logic              power;
        logic              loaded;
        logic [FrameW-1:0] bright_target;
        logic [FrameW-1:0] colour_target;
        logic [FrameW-1:0] bright_current;
        logic [FrameW-1:0] colour_current;
    } drc_state_t;

    typedef struct packed {
        logic              light_on;
        logic [FrameW-1:0] brightness_level;
        logic [FrameW-1:0] colour_temp_index;
        logic              strip_update;
        logic              animating;
    } drc_result_t;

    typedef struct packed {
        logic              moved;
        logic [FrameW-1:0] value;
    } drc_move_t;

    // Moves a current frame one count toward its target.
    function automatic drc_move_t drc_move(input logic [FrameW-1:0] cur,
                                           input logic [FrameW-1:0] tgt);
        drc_move_t r;
        r.moved = (cur != tgt);
        if (cur > tgt)
            r.value = cur - 8'd1;
        else if (cur < tgt)
            r.value = cur + 8'd1;
        else
            r.value = cur;
        return r;
    endfunction

    function automatic logic [FrameW-1:0] drc_limit(input logic [FrameW-1:0] v,
                                                    input logic [FrameW-1:0] hi);
        return (v > hi) ? hi : v;
    endfunction

    // Adds a signed delta to a target and clamps it; the upper bound is tested first.
    function automatic logic [FrameW-1:0] drc_saturate(input logic [FrameW-1:0] t,
                                                       input logic [DeltaW-1:0] d,
                                                       input logic [FrameW-1:0] lo,
                                                       input logic [FrameW-1:0] hi);
        logic signed [FrameW+2:0] sum;
        logic [FrameW-1:0]        r;
        sum = $signed({3'b000, t}) + $signed({{2{d[DeltaW-1]}}, d});
        if (sum > $signed({3'b000, hi}))
            r = hi;
        else if (sum < $signed({3'b000, lo}))
            r = lo;
        else
            r = sum[FrameW-1:0];
        return r;
    endfunction

    function automatic logic [FrameW-1:0] drc_next_preset(input logic [FrameW-1:0] prev);
        logic [FrameW-1:0] r;
        if (prev < PRESET_0)
            r = PRESET_0;
        else if (prev < PRESET_1)
            r = PRESET_1;
        else if (prev < PRESET_2)
            r = PRESET_2;
        else
            r = PRESET_0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/drc_cfg_regs.sv
// Configuration register file of the dimmer ramp controller.
// Depends on drc_pkg for register indexes, reset values and drc_cfg_t.
`default_nettype none

module drc_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [drc_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [drc_pkg::FrameW-1:0]    cfg_data,
    output drc_pkg::drc_cfg_t                  cfg
);
    import drc_pkg::*;

    drc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_brightness      <= RST_MAX_BRIGHTNESS;
            cfg_reg.min_brightness      <= RST_MIN_BRIGHTNESS;
            cfg_reg.max_colour_temp     <= RST_MAX_COLOUR_TEMP;
            cfg_reg.min_colour_temp     <= RST_MIN_COLOUR_TEMP;
            cfg_reg.default_brightness  <= RST_DEFAULT_BRIGHTNESS;
            cfg_reg.default_colour_temp <= RST_DEFAULT_COLOUR_TEMP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MAX_BRIGHTNESS:      cfg_reg.max_brightness      <= cfg_data;
                REG_MIN_BRIGHTNESS:      cfg_reg.min_brightness      <= cfg_data;
                REG_MAX_COLOUR_TEMP:     cfg_reg.max_colour_temp     <= cfg_data;
                REG_MIN_COLOUR_TEMP:     cfg_reg.min_colour_temp     <= cfg_data;
                REG_DEFAULT_BRIGHTNESS:  cfg_reg.default_brightness  <= cfg_data;
                REG_DEFAULT_COLOUR_TEMP: cfg_reg.default_colour_temp <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/drc_step.sv
// Next-state and result logic for one command word of the dimmer ramp controller.
// Depends on drc_pkg for the state, config and result structs and helpers.
`default_nettype none

module drc_step (
    input  wire drc_pkg::drc_cfg_t            cfg,
    input  wire drc_pkg::drc_state_t          state_cur,
    input  wire logic [drc_pkg::CmdW-1:0]     command,
    input  wire logic [drc_pkg::DeltaW-1:0]   delta,
    output drc_pkg::drc_state_t               state_next,
    output drc_pkg::drc_result_t              result
);
    import drc_pkg::*;

    always_comb
    begin
        drc_state_t s;
        drc_move_t  entry_c, entry_b, cmd_c, cmd_b, on_c, on_b;
        logic       upd;
        logic       mov;
        logic       do_step;

        s       = state_cur;
        upd     = 1'b0;
        mov     = 1'b0;
        do_step = 1'b0;

        // The first word after reset loads the default targets and, when on,
        // performs the power-on entry before its own command.
        if (!s.loaded)
        begin
            s.loaded        = 1'b1;
            s.bright_target = cfg.default_brightness;
            s.colour_target = cfg.default_colour_temp;
            if (s.power)
            begin
                s.bright_target = drc_limit(s.bright_target, cfg.max_brightness);
                s.colour_target = drc_limit(s.colour_target, cfg.max_colour_temp);
                s.bright_current = '0;
                s.colour_current = '0;
            end
        end
        entry_c = drc_move(s.colour_current, s.colour_target);
        entry_b = drc_move(s.bright_current, s.bright_target);
        if (!state_cur.loaded && state_cur.power)
        begin
            s.colour_current = entry_c.value;
            s.bright_current = entry_b.value;
            mov = entry_c.moved | entry_b.moved;
            upd = mov;
        end

        if (s.power)
        begin
            unique case (command)
                CMD_POWER:
                begin
                    s.power = 1'b0;
                    upd     = 1'b1;
                    mov     = 1'b0;
                end
                CMD_COLOUR_DELTA:
                begin
                    s.colour_target = drc_saturate(s.colour_target, delta,
                                                   cfg.min_colour_temp, cfg.max_colour_temp);
                    do_step = 1'b1;
                end
                CMD_COLOUR_PRESET:
                begin
                    s.colour_target = drc_next_preset(s.colour_target);
                    do_step = 1'b1;
                end
                CMD_BRIGHT_DELTA:
                begin
                    s.bright_target = drc_saturate(s.bright_target, delta,
                                                   cfg.min_brightness, cfg.max_brightness);
                    do_step = 1'b1;
                end
                CMD_TICK: do_step = 1'b1;
                default: ;
            endcase
        end

        cmd_c = drc_move(s.colour_current, s.colour_target);
        cmd_b = drc_move(s.bright_current, s.bright_target);
        if (do_step)
        begin
            s.colour_current = cmd_c.value;
            s.bright_current = cmd_b.value;
            if (cmd_c.moved || cmd_b.moved)
            begin
                mov = 1'b1;
                upd = 1'b1;
            end
        end

        // Power-on from the off state: restart the frames from zero and step once.
        on_c = drc_move('0, drc_limit(state_cur.colour_target, cfg.max_colour_temp));
        on_b = drc_move('0, drc_limit(state_cur.bright_target, cfg.max_brightness));
        if (!state_cur.power && command == CMD_POWER)
        begin
            s.power          = 1'b1;
            s.colour_target  = drc_limit(state_cur.colour_target, cfg.max_colour_temp);
            s.bright_target  = drc_limit(state_cur.bright_target, cfg.max_brightness);
            s.colour_current = on_c.value;
            s.bright_current = on_b.value;
            if (on_c.moved || on_b.moved)
            begin
                mov = 1'b1;
                upd = 1'b1;
            end
        end

        state_next               = s;
        result.light_on          = s.power;
        result.brightness_level  = s.power ? s.bright_current : '0;
        result.colour_temp_index = s.colour_current;
        result.strip_update      = upd;
        result.animating         = mov;
    end

endmodule

`default_nettype wire

FILE: rtl/dimmer_ramp_controller_core.sv
// Dimmer ramp controller top level: input register, combinational update logic,
// result register. An accepted command word is held in the input register and its
// result word in the result register. Throughput is one word per cycle while
// out_ready is high. Reset (rst_n, asynchronous) puts the bar in the on state
// with targets not yet loaded, all frames at zero and the registers at their
// defaults; both pipeline stages come up empty.
`default_nettype none

module dimmer_ramp_controller_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [drc_pkg::CfgIdxW-1:0]   cfg_index,
    input  wire logic [drc_pkg::FrameW-1:0]    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [drc_pkg::CmdW-1:0]      command,
    input  wire logic [drc_pkg::DeltaW-1:0]    delta,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               light_on,
    output logic [drc_pkg::FrameW-1:0]         brightness_level,
    output logic [drc_pkg::FrameW-1:0]         colour_temp_index,
    output logic                               strip_update,
    output logic                               animating
);
    import drc_pkg::*;

    drc_cfg_t    cfg;
    drc_state_t  state_reg;
    drc_state_t  state_next;
    drc_result_t result_next;
    drc_result_t result_reg;

    logic              s1_valid_reg;
    logic [CmdW-1:0]   s1_command_reg;
    logic [DeltaW-1:0] s1_delta_reg;
    logic              out_valid_reg;
    logic              advance;

    drc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    drc_step u_step (
        .cfg        (cfg),
        .state_cur  (state_reg),
        .command    (s1_command_reg),
        .delta      (s1_delta_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // The held word moves on whenever the result register is free or draining.
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_command_reg <= command;
            s1_delta_reg   <= delta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.power          <= 1'b1;
            state_reg.loaded         <= 1'b0;
            state_reg.bright_target  <= '0;
            state_reg.colour_target  <= '0;
            state_reg.bright_current <= '0;
            state_reg.colour_current <= '0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign light_on          = result_reg.light_on;
    assign brightness_level  = result_reg.brightness_level;
    assign colour_temp_index = result_reg.colour_temp_index;
    assign strip_update      = result_reg.strip_update;
    assign animating         = result_reg.animating;

endmodule

`default_nettype wire

FILE: verif/drc_light_checker.sv
`timescale 1ns / 100ps
// Checker for the dimmer ramp controller: it mirrors the register writes, predicts
// one result word for each accepted command word and compares the words in order.
// Depends on drc_pkg.
module drc_light_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [drc_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [drc_pkg::FrameW-1:0]  cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [drc_pkg::CmdW-1:0]    command,
    input  logic [drc_pkg::DeltaW-1:0]  delta,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        light_on,
    input  logic [drc_pkg::FrameW-1:0]  brightness_level,
    input  logic [drc_pkg::FrameW-1:0]  colour_temp_index,
    input  logic                        strip_update,
    input  logic                        animating,
    output int                          mismatches,
    output int                          words_pending
);

    drc_pkg::drc_cfg_t               regs;
    logic                            lit;
    logic                            goals_loaded;
    logic [drc_pkg::FrameW-1:0]      bright_goal;
    logic [drc_pkg::FrameW-1:0]      colour_goal;
    logic [drc_pkg::FrameW-1:0]      bright_now;
    logic [drc_pkg::FrameW-1:0]      colour_now;
    drc_pkg::drc_result_t            expected_words[$];

    task automatic nudge_frame(inout logic [drc_pkg::FrameW-1:0] now,
                               input logic [drc_pkg::FrameW-1:0] goal,
                               output bit moved);
        moved = (now != goal);
        if (now > goal)
            now = now - 8'd1;
        else if (now < goal)
            now = now + 8'd1;
    endtask

    // Colour moves first, then brightness.
    task automatic ramp_step(output bit moved);
        bit colour_moved;
        bit bright_moved;
        nudge_frame(colour_now, colour_goal, colour_moved);
        nudge_frame(bright_now, bright_goal, bright_moved);
        moved = colour_moved || bright_moved;
    endtask

    task automatic power_up_frames(output bit moved);
        bright_now = '0;
        colour_now = '0;
        if (bright_goal > regs.max_brightness)
            bright_goal = regs.max_brightness;
        if (colour_goal > regs.max_colour_temp)
            colour_goal = regs.max_colour_temp;
        ramp_step(moved);
    endtask

    // The sum is formed at full width; the upper bound is tested first.
    function automatic logic [drc_pkg::FrameW-1:0] clamp_goal(
            input logic [drc_pkg::FrameW-1:0] goal,
            input logic [drc_pkg::DeltaW-1:0] d,
            input logic [drc_pkg::FrameW-1:0] lo,
            input logic [drc_pkg::FrameW-1:0] hi);
        int step_val;
        int sum;
        step_val = $signed(d);
        sum = int'(goal) + step_val;
        if (sum > int'(hi))
            return hi;
        else if (sum < int'(lo))
            return lo;
        else
            return sum[drc_pkg::FrameW-1:0];
    endfunction

    task automatic predict_word(input logic [drc_pkg::CmdW-1:0] cmd,
                                input logic [drc_pkg::DeltaW-1:0] d,
                                output drc_pkg::drc_result_t res);
        bit moved;
        bit update;
        bit m;
        moved = 0;
        update = 0;
        m = 0;
        if (!goals_loaded) begin
            goals_loaded = 1'b1;
            bright_goal = regs.default_brightness;
            colour_goal = regs.default_colour_temp;
            if (lit) begin
                power_up_frames(moved);
                update = moved;
            end
        end
        if (lit) begin
            case (cmd)
                drc_pkg::CMD_POWER:
                begin
                    lit = 1'b0;
                    update = 1;
                    moved = 0;
                end
                drc_pkg::CMD_COLOUR_DELTA:
                begin
                    colour_goal = clamp_goal(colour_goal, d, regs.min_colour_temp,
                                             regs.max_colour_temp);
                    ramp_step(m);
                end
                drc_pkg::CMD_COLOUR_PRESET:
                begin
                    if (colour_goal < drc_pkg::PRESET_0)
                        colour_goal = drc_pkg::PRESET_0;
                    else if (colour_goal < drc_pkg::PRESET_1)
                        colour_goal = drc_pkg::PRESET_1;
                    else if (colour_goal < drc_pkg::PRESET_2)
                        colour_goal = drc_pkg::PRESET_2;
                    else
                        colour_goal = drc_pkg::PRESET_0;
                    ramp_step(m);
                end
                drc_pkg::CMD_BRIGHT_DELTA:
                begin
                    bright_goal = clamp_goal(bright_goal, d, regs.min_brightness,
                                             regs.max_brightness);
                    ramp_step(m);
                end
                drc_pkg::CMD_TICK:
                    ramp_step(m);
                default:
                    m = 0;
            endcase
            if (m) begin
                moved = 1;
                update = 1;
            end
        end
        else if (cmd == drc_pkg::CMD_POWER) begin
            lit = 1'b1;
            power_up_frames(m);
            if (m) begin
                moved = 1;
                update = 1;
            end
        end
        res.light_on = lit;
        res.brightness_level = lit ? bright_now : '0;
        res.colour_temp_index = colour_now;
        res.strip_update = update;
        res.animating = moved;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_word(input drc_pkg::drc_result_t got);
        drc_pkg::drc_result_t want;
        if (expected_words.size() == 0) begin
            mismatches++;
            $display("%0t: result word with none expected: expected nothing, got %p",
                     $time, got);
        end
        else begin
            want = expected_words.pop_front();
            compare_field("light_on", want.light_on, got.light_on);
            compare_field("brightness_level", want.brightness_level, got.brightness_level);
            compare_field("colour_temp_index", want.colour_temp_index,
                          got.colour_temp_index);
            compare_field("strip_update", want.strip_update, got.strip_update);
            compare_field("animating", want.animating, got.animating);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        drc_pkg::drc_result_t got;
        drc_pkg::drc_result_t want;
        if (!rst_n) begin
            regs.max_brightness = drc_pkg::RST_MAX_BRIGHTNESS;
            regs.min_brightness = drc_pkg::RST_MIN_BRIGHTNESS;
            regs.max_colour_temp = drc_pkg::RST_MAX_COLOUR_TEMP;
            regs.min_colour_temp = drc_pkg::RST_MIN_COLOUR_TEMP;
            regs.default_brightness = drc_pkg::RST_DEFAULT_BRIGHTNESS;
            regs.default_colour_temp = drc_pkg::RST_DEFAULT_COLOUR_TEMP;
            lit = 1'b1;
            goals_loaded = 1'b0;
            bright_goal = '0;
            colour_goal = '0;
            bright_now = '0;
            colour_now = '0;
            expected_words.delete();
            words_pending <= 0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    drc_pkg::REG_MAX_BRIGHTNESS:      regs.max_brightness = cfg_data;
                    drc_pkg::REG_MIN_BRIGHTNESS:      regs.min_brightness = cfg_data;
                    drc_pkg::REG_MAX_COLOUR_TEMP:     regs.max_colour_temp = cfg_data;
                    drc_pkg::REG_MIN_COLOUR_TEMP:     regs.min_colour_temp = cfg_data;
                    drc_pkg::REG_DEFAULT_BRIGHTNESS:  regs.default_brightness = cfg_data;
                    drc_pkg::REG_DEFAULT_COLOUR_TEMP: regs.default_colour_temp = cfg_data;
                    default:                          regs = regs;
                endcase
            end
            // A result word leaving now always belongs to an earlier command word.
            if (out_valid && out_ready) begin
                got.light_on = light_on;
                got.brightness_level = brightness_level;
                got.colour_temp_index = colour_temp_index;
                got.strip_update = strip_update;
                got.animating = animating;
                check_word(got);
            end
            if (in_valid && in_ready) begin
                predict_word(command, delta, want);
                expected_words.push_back(want);
            end
            words_pending <= expected_words.size();
        end
    end

endmodule

FILE: verif/dimmer_ramp_controller_core_test.sv
`timescale 1ns / 100ps
// Testbench top for dimmer_ramp_controller_core: drives directed and random command
// words and register settings; drc_light_checker does the prediction and comparison.
// Depends on drc_pkg, drc_light_checker and the controller RTL.
module dimmer_ramp_controller_core_test;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_write;
    logic [drc_pkg::CfgIdxW-1:0] cfg_index;
    logic [drc_pkg::FrameW-1:0]  cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [drc_pkg::CmdW-1:0]    command;
    logic [drc_pkg::DeltaW-1:0]  delta;
    logic                        out_valid;
    logic                        out_ready;
    logic                        light_on;
    logic [drc_pkg::FrameW-1:0]  brightness_level;
    logic [drc_pkg::FrameW-1:0]  colour_temp_index;
    logic                        strip_update;
    logic                        animating;
    int                          mismatches;
    int                          words_pending;
    int                          send_idle_pct;
    int                          take_stall_pct;

    dimmer_ramp_controller_core i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .delta             (delta),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .light_on          (light_on),
        .brightness_level  (brightness_level),
        .colour_temp_index (colour_temp_index),
        .strip_update      (strip_update),
        .animating         (animating)
    );

    drc_light_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .delta             (delta),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .light_on          (light_on),
        .brightness_level  (brightness_level),
        .colour_temp_index (colour_temp_index),
        .strip_update      (strip_update),
        .animating         (animating),
        .mismatches        (mismatches),
        .words_pending     (words_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= take_stall_pct);
    end

    initial
    begin
        #12_000_000;
        $display("dimmer_ramp_controller_core: mismatch");
        $finish;
    end

    // Valid stays high across back-to-back words; it only drops while the task idles.
    task automatic send_word(input logic [drc_pkg::CmdW-1:0] cmd,
                             input logic [drc_pkg::DeltaW-1:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        delta <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random_word();
        int                         pick;
        int                         step_val;
        logic [drc_pkg::CmdW-1:0]   cmd;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            cmd = drc_pkg::CMD_POWER;
        else if (pick < 9)
            cmd = drc_pkg::CMD_TICK + 3'($urandom_range(1, 3));
        else if (pick < 30)
            cmd = drc_pkg::CMD_COLOUR_DELTA;
        else if (pick < 40)
            cmd = drc_pkg::CMD_COLOUR_PRESET;
        else if (pick < 62)
            cmd = drc_pkg::CMD_BRIGHT_DELTA;
        else
            cmd = drc_pkg::CMD_TICK;
        // Small steps, drawn half of the time, keep targets near the current frames so ramps settle.
        if ($urandom_range(0, 1) == 1)
            step_val = int'($urandom_range(0, 12)) - 6;
        else
            step_val = int'($urandom_range(0, 510)) - 255;
        send_word(cmd, step_val[drc_pkg::DeltaW-1:0]);
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [drc_pkg::CfgIdxW-1:0] idx,
                             input logic [drc_pkg::FrameW-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [7:0] max_b, input logic [7:0] min_b,
                             input logic [7:0] max_c, input logic [7:0] min_c,
                             input logic [7:0] def_b, input logic [7:0] def_c);
        write_reg(drc_pkg::REG_MAX_BRIGHTNESS, max_b);
        write_reg(drc_pkg::REG_MIN_BRIGHTNESS, min_b);
        write_reg(drc_pkg::REG_MAX_COLOUR_TEMP, max_c);
        write_reg(drc_pkg::REG_MIN_COLOUR_TEMP, min_c);
        write_reg(drc_pkg::REG_DEFAULT_BRIGHTNESS, def_b);
        write_reg(drc_pkg::REG_DEFAULT_COLOUR_TEMP, def_c);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = drc_pkg::CMD_TICK;
        delta = '0;
        out_ready = 1'b0;
        send_idle_pct = 30;
        take_stall_pct = 68;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first word loads the default targets before it is handled.
        send_word(drc_pkg::CMD_TICK, 9'd0);
        send_word(drc_pkg::CMD_BRIGHT_DELTA, 9'd255);
        send_word(drc_pkg::CMD_BRIGHT_DELTA, 9'h101);
        send_word(drc_pkg::CMD_BRIGHT_DELTA, 9'h1FF);
        send_word(drc_pkg::CMD_COLOUR_DELTA, 9'd255);
        send_word(drc_pkg::CMD_COLOUR_DELTA, 9'h101);
        // Walk the presets through the wrap back to the first one.
        send_word(drc_pkg::CMD_COLOUR_PRESET, 9'd0);
        send_word(drc_pkg::CMD_COLOUR_PRESET, 9'h0AA);
        send_word(drc_pkg::CMD_COLOUR_PRESET, 9'h155);
        send_word(drc_pkg::CMD_COLOUR_PRESET, 9'd0);
        send_word(drc_pkg::CMD_COLOUR_DELTA, 9'd1);
        send_word(drc_pkg::CMD_TICK, 9'h1FF);
        send_word(drc_pkg::CMD_TICK + 3'd1, 9'd3);
        send_word(drc_pkg::CMD_POWER, 9'd0);
        // While off, everything but the power toggle is ignored.
        send_word(drc_pkg::CMD_TICK, 9'd0);
        send_word(drc_pkg::CMD_BRIGHT_DELTA, 9'd100);
        send_word(drc_pkg::CMD_COLOUR_DELTA, 9'h1F0);
        send_word(drc_pkg::CMD_COLOUR_PRESET, 9'd0);
        send_word(drc_pkg::CMD_TICK + 3'd3, 9'd0);
        send_word(drc_pkg::CMD_POWER, 9'd0);
        send_word(drc_pkg::CMD_TICK + 3'd2, 9'd7);
        send_word(drc_pkg::CMD_BRIGHT_DELTA, 9'd0);
        send_word(drc_pkg::CMD_TICK, 9'd0);

        for (int phase = 0; phase < 6; phase++)
        begin
            settle_idle();
            case (phase)
                0: load_regs(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255);
                1: load_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                2: load_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                // Crossed bounds: a sum above the upper bound gives it, any other sum the lower bound.
                3: load_regs(8'd50, 8'd200, 8'd20, 8'd40, 8'd7, 8'd9);
                4: load_regs(8'd180, 8'd30, 8'd63, 8'd10, 8'd90, 8'd35);
                default: load_regs(8'($urandom), 8'($urandom_range(0, 80)),
                                   8'($urandom), 8'($urandom_range(0, 40)),
                                   8'($urandom), 8'($urandom));
            endcase
            if (phase < 2)
            begin
                send_idle_pct = 30;
                take_stall_pct = 68;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 68;
                take_stall_pct = 30;
            end
            else
            begin
                send_idle_pct = 0;
                take_stall_pct = 0;
            end
            repeat (280) send_random_word();
        end

        settle_idle();
        if (mismatches == 0)
            $display("dimmer_ramp_controller_core: match");
        else
            $display("dimmer_ramp_controller_core: mismatch");
        $finish;
    end

endmodule
